// ===== src/symbol_table_insert_lookup_unit_macros.svh =====
// Assertion macros for the symbol table unit.
`ifndef SYMBOL_TABLE_INSERT_LOOKUP_UNIT_MACROS_SVH
`define SYMBOL_TABLE_INSERT_LOOKUP_UNIT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define STIL_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("symbol table assertion failed");

// The consequent holds in the cycle after the antecedent.
`define STIL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("symbol table assertion failed");

`endif

// ===== src/stil_pkg.sv =====
package stil_pkg;

  localparam int unsigned KEY_FIELD_W = 64;
  localparam int unsigned INDEX_W     = 7;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_DUPLICATE = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam logic [1:0] KIND_HIT  = 2'd0;
  localparam logic [1:0] KIND_MISS = 2'd1;
  localparam logic [1:0] KIND_FULL = 2'd2;
  localparam logic [1:0] KIND_NEW  = 2'd3;

  typedef struct packed {
    logic                   command;
    logic [KEY_FIELD_W-1:0] symbol_key;
    logic [15:0]            in_address;
    logic                   in_type;
    logic [1:0]             in_category;
    logic                   in_scope;
    logic [15:0]            in_label;
    logic [4:0]             in_param_count;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [INDEX_W-1:0] entry_index;
    logic [15:0]        out_address;
    logic               out_type;
    logic [1:0]         out_category;
    logic               out_scope;
    logic [15:0]        out_label;
    logic [4:0]         out_param_count;
  } rsp_item_t;

  typedef struct packed {
    logic [4:0]  param_count;
    logic [15:0] label;
    logic        scope;
    logic [1:0]  category;
    logic        data_type;
    logic [15:0] address;
  } attr_t;

  localparam int unsigned ATTR_W = $bits(attr_t);

  typedef struct packed {
    logic       load;
    logic       search;
    logic       emit;
    logic [1:0] kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_lookup;
    logic full;
    logic hit;
    logic done;
    logic out_free;
  } ctrl_status_t;

endpackage

// ===== src/stil_ram.sv =====
module stil_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/stil_ctrl.sv =====
module stil_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  stil_pkg::ctrl_status_t status,
  output stil_pkg::ctrl_cmd_t   ctrl
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_EMIT   = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [1:0] kind;
  logic [1:0] kind_next;

  always_comb begin
    state_next  = state;
    kind_next   = kind;
    cmd_ready   = 1'b0;
    ctrl.load   = 1'b0;
    ctrl.search = 1'b0;
    ctrl.emit   = 1'b0;
    ctrl.kind   = kind;
    case (state)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          ctrl.load  = 1'b1;
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        ctrl.search = 1'b1;
        if (!status.is_lookup && status.full) begin
          kind_next  = stil_pkg::KIND_FULL;
          state_next = S_EMIT;
        end else if (status.hit) begin
          kind_next  = stil_pkg::KIND_HIT;
          state_next = S_EMIT;
        end else if (status.done) begin
          kind_next  = status.is_lookup ? stil_pkg::KIND_MISS : stil_pkg::KIND_NEW;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          ctrl.emit  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= stil_pkg::KIND_MISS;
    end else begin
      state <= state_next;
      kind  <= kind_next;
    end
  end

endmodule

// ===== src/stil_datapath.sv =====
module stil_datapath #(
  parameter int unsigned TABLE_DEPTH = 128,
  parameter int unsigned KEY_WIDTH   = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  stil_pkg::cmd_item_t    cmd_item,
  input  stil_pkg::ctrl_cmd_t    ctrl,
  output stil_pkg::ctrl_status_t status,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  output stil_pkg::rsp_item_t    rsp_item
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  stil_pkg::cmd_item_t item;
  stil_pkg::attr_t     new_attr;
  stil_pkg::attr_t     rd_attr;
  stil_pkg::attr_t     hit_attr;
  stil_pkg::attr_t     res_attr;
  stil_pkg::rsp_item_t res;

  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     remain;
  logic [CNT_W-1:0]     remain_dec;
  logic                 rd_valid;
  logic [IDX_W-1:0]     rd_slot;
  logic [IDX_W-1:0]     hit_slot;
  logic [KEY_WIDTH-1:0] rd_key;
  logic [KEY_WIDTH-1:0] item_key;
  logic                 rd_en;
  logic                 wr_en;
  logic                 hit;
  logic [1:0]           res_status;
  logic [6:0]           res_index;

  assign item_key   = item.symbol_key[KEY_WIDTH-1:0];
  assign remain_dec = remain - 1'b1;
  assign rd_en      = ctrl.search && (remain != '0);
  assign wr_en      = ctrl.emit && (ctrl.kind == stil_pkg::KIND_NEW);
  assign hit        = rd_valid && (rd_key == item_key);

  assign new_attr.param_count = item.in_param_count;
  assign new_attr.label       = item.in_label;
  assign new_attr.scope       = item.in_scope;
  assign new_attr.category    = item.in_category;
  assign new_attr.data_type   = item.in_type;
  assign new_attr.address     = item.in_address;

  stil_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count[IDX_W-1:0]),
    .wdata (item_key),
    .re    (rd_en),
    .raddr (remain_dec[IDX_W-1:0]),
    .rdata (rd_key)
  );

  stil_ram #(
    .WIDTH (stil_pkg::ATTR_W),
    .DEPTH (TABLE_DEPTH)
  ) u_attr_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count[IDX_W-1:0]),
    .wdata (new_attr),
    .re    (rd_en),
    .raddr (remain_dec[IDX_W-1:0]),
    .rdata (rd_attr)
  );

  assign status.is_lookup = (item.command == stil_pkg::CMD_LOOKUP);
  assign status.full      = (count == CNT_W'(TABLE_DEPTH));
  assign status.hit       = hit;
  assign status.done      = !rd_valid && (remain == '0);
  assign status.out_free  = !rsp_valid || rsp_ready;

  always_comb begin
    res_status = stil_pkg::ST_NOT_FOUND;
    res_index  = '0;
    res_attr   = '0;
    case (ctrl.kind)
      stil_pkg::KIND_HIT: begin
        res_status = status.is_lookup ? stil_pkg::ST_OK : stil_pkg::ST_DUPLICATE;
        res_index  = 7'(hit_slot);
        res_attr   = hit_attr;
      end
      stil_pkg::KIND_NEW: begin
        res_status = stil_pkg::ST_OK;
        res_index  = 7'(count);
        res_attr   = new_attr;
      end
      stil_pkg::KIND_FULL: begin
        res_status = stil_pkg::ST_FULL;
      end
      default: begin
        res_status = stil_pkg::ST_NOT_FOUND;
      end
    endcase
    res.status          = res_status;
    res.entry_index     = res_index;
    res.out_address     = res_attr.address;
    res.out_type        = res_attr.data_type;
    res.out_category    = res_attr.category;
    res.out_scope       = res_attr.scope;
    res.out_label       = res_attr.label;
    res.out_param_count = res_attr.param_count;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      item <= cmd_item;
    end
    if (ctrl.search && hit) begin
      hit_slot <= rd_slot;
      hit_attr <= rd_attr;
    end
    if (rd_en) begin
      rd_slot <= remain_dec[IDX_W-1:0];
    end
    if (ctrl.emit) begin
      rsp_item <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      remain    <= '0;
      rd_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (ctrl.load) begin
        remain   <= count;
        rd_valid <= 1'b0;
      end else if (ctrl.search) begin
        rd_valid <= rd_en;
        if (rd_en) begin
          remain <= remain_dec;
        end
      end
      if (wr_en) begin
        count <= count + 1'b1;
      end
      if (ctrl.emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/symbol_table_insert_lookup_unit.sv =====
// Channel   Direction  Payload               Handshake
// cmd       in         stil_pkg::cmd_item_t  cmd_valid / cmd_ready
// rsp       out        stil_pkg::rsp_item_t  rsp_valid / rsp_ready
//
// One item is worked on at a time. The search reads one stored entry per cycle
// through the registered read port of the key and attribute memories, newest first.
// The search stops at the first match; a full-table insert is answered without searching.
// Reset clears the entry count, the search and response state and the control state; the
// memories need no clearing. A held result does not block acceptance of the next item,
// but that item waits in the emit state until the held result has been taken.

`include "symbol_table_insert_lookup_unit_macros.svh"

module symbol_table_insert_lookup_unit #(
  parameter int unsigned TABLE_DEPTH = 128,
  parameter int unsigned KEY_WIDTH   = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  stil_pkg::cmd_item_t cmd_item,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output stil_pkg::rsp_item_t rsp_item
);

  stil_pkg::ctrl_cmd_t    ctrl_cmd;
  stil_pkg::ctrl_status_t ctrl_status;

  stil_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .status    (ctrl_status),
    .ctrl      (ctrl_cmd)
  );

  stil_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd_item  (cmd_item),
    .ctrl      (ctrl_cmd),
    .status    (ctrl_status),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_item  (rsp_item)
  );

  `STIL_ASSERT_NEXT(a_one_item, cmd_valid && cmd_ready, !cmd_ready)
  `STIL_ASSERT_IMPLIES(a_emit_room, ctrl_cmd.emit, !rsp_valid || rsp_ready)
  `STIL_ASSERT_IMPLIES(a_new_not_full, ctrl_cmd.emit && (ctrl_cmd.kind == stil_pkg::KIND_NEW), !ctrl_status.full)
  `STIL_ASSERT_IMPLIES(a_search_busy, ctrl_cmd.search, !cmd_ready)

endmodule

// ===== tb/sv/symbol_table_insert_lookup_unit_test.sv =====
module symbol_table_insert_lookup_unit_test;

  typedef stil_pkg::cmd_item_t cmd_item_t;
  typedef stil_pkg::rsp_item_t rsp_item_t;
  typedef stil_pkg::attr_t     attr_t;

  localparam logic       CMD_INSERT   = stil_pkg::CMD_INSERT;
  localparam logic       CMD_LOOKUP   = stil_pkg::CMD_LOOKUP;
  localparam logic [1:0] ST_OK        = stil_pkg::ST_OK;
  localparam logic [1:0] ST_NOT_FOUND = stil_pkg::ST_NOT_FOUND;
  localparam logic [1:0] ST_DUPLICATE = stil_pkg::ST_DUPLICATE;
  localparam logic [1:0] ST_FULL      = stil_pkg::ST_FULL;
  localparam int unsigned INDEX_W     = stil_pkg::INDEX_W;

  localparam int unsigned TABLE_DEPTH    = 128;
  localparam int unsigned POOL_SIZE      = 160;
  localparam int unsigned RANDOM_ITEMS   = 1030;
  localparam int unsigned QUIET_ITEMS    = 150;
  localparam int unsigned PAUSE_AT       = 400;
  localparam int unsigned DRAIN_CYCLES   = 200;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  localparam logic [1:0] CAT_FUNCTION  = 2'd0;
  localparam logic [1:0] CAT_PARAMETER = 2'd1;
  localparam logic [1:0] CAT_VARIABLE  = 2'd2;
  localparam logic [1:0] CAT_INVALID   = 2'd3;
  localparam logic       TYPE_INTEGER  = 1'b0;
  localparam logic       TYPE_LOGICAL  = 1'b1;
  localparam logic       SCOPE_GLOBAL  = 1'b0;
  localparam logic       SCOPE_LOCAL   = 1'b1;

  localparam logic WANT_GIVEN     = 1'b1;
  localparam logic WANT_PREDICTED = 1'b0;

  localparam logic [63:0] KEY_ZERO     = 64'h0;
  localparam logic [63:0] KEY_ALL_ONES = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] KEY_TOP      = 64'h8000_0000_0000_0000;
  localparam logic [63:0] KEY_MAIN     = 64'h0000_0000_6d61_696e;
  localparam logic [63:0] KEY_MAIO     = 64'h0000_0000_6d61_696f;
  localparam logic [63:0] KEY_COUNTER  = 64'h0063_6f75_6e74_6572;
  localparam logic [63:0] KEY_N        = 64'h0000_0000_0000_006e;
  localparam logic [63:0] KEY_FLAG     = 64'h0000_0000_666c_6167;

  localparam rsp_item_t NO_RSP = '0;

  typedef struct packed {
    cmd_item_t item;
    logic      typed;
    rsp_item_t want;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_ready;
  cmd_item_t cmd_item = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rsp_item_t rsp_item;

  logic [63:0] stored_keys [TABLE_DEPTH];
  attr_t       stored_attrs[TABLE_DEPTH];
  int unsigned stored_count = 0;

  rsp_item_t   expected_rsp[$];
  stim_row_t   directed_rows[$];
  logic [63:0] key_pool[POOL_SIZE];

  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned rsp_hold = 0;
  bit          quiet_phase = 1'b0;

  symbol_table_insert_lookup_unit #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_WIDTH  (64)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd_item (cmd_item),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_item (rsp_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic find_key(input logic [63:0] key, output int unsigned slot);
    int n;
    slot = 0;
    for (n = int'(stored_count) - 1; n >= 0; n--) begin
      if (stored_keys[n] == key) begin
        slot = unsigned'(n);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic rsp_item_t response_from(input logic [1:0] status,
                                              input int unsigned slot, input attr_t a);
    rsp_item_t r;
    r.status          = status;
    r.entry_index     = slot[INDEX_W-1:0];
    r.out_address     = a.address;
    r.out_type        = a.data_type;
    r.out_category    = a.category;
    r.out_scope       = a.scope;
    r.out_label       = a.label;
    r.out_param_count = a.param_count;
    return r;
  endfunction

  function automatic rsp_item_t predict_response(input cmd_item_t c);
    rsp_item_t   r;
    attr_t       a;
    int unsigned slot;
    logic        hit;
    r = '0;
    hit = find_key(c.symbol_key, slot);
    if (c.command == CMD_LOOKUP) begin
      if (hit) begin
        r = response_from(ST_OK, slot, stored_attrs[slot]);
      end else begin
        r.status = ST_NOT_FOUND;
      end
    end else if (stored_count >= TABLE_DEPTH) begin
      r.status = ST_FULL;
    end else if (hit) begin
      r = response_from(ST_DUPLICATE, slot, stored_attrs[slot]);
    end else begin
      a.address     = c.in_address;
      a.data_type   = c.in_type;
      a.category    = c.in_category;
      a.scope       = c.in_scope;
      a.label       = c.in_label;
      a.param_count = c.in_param_count;
      stored_keys[stored_count]  = c.symbol_key;
      stored_attrs[stored_count] = a;
      r = response_from(ST_OK, stored_count, a);
      stored_count++;
    end
    return r;
  endfunction

  function automatic cmd_item_t random_command();
    cmd_item_t c;
    c.command = ($urandom_range(0, 99) < 25) ? CMD_INSERT : CMD_LOOKUP;
    if ($urandom_range(0, 9) < 7) begin
      c.symbol_key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    end else begin
      c.symbol_key = {$urandom, $urandom};
    end
    c.in_address     = 16'($urandom);
    c.in_type        = 1'($urandom);
    c.in_category    = 2'($urandom);
    c.in_scope       = 1'($urandom);
    c.in_label       = 16'($urandom);
    c.in_param_count = 5'($urandom);
    return c;
  endfunction

  task automatic add_row(input cmd_item_t item, input logic typed, input rsp_item_t want);
    stim_row_t row;
    row.item  = item;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  task automatic report_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    error_count++;
  endtask

  task automatic compare_response(input rsp_item_t want, input rsp_item_t got);
    if (got.status !== want.status)
      report_field("status", 16'(want.status), 16'(got.status));
    if (got.entry_index !== want.entry_index)
      report_field("entry_index", 16'(want.entry_index), 16'(got.entry_index));
    if (got.out_address !== want.out_address)
      report_field("out_address", want.out_address, got.out_address);
    if (got.out_type !== want.out_type)
      report_field("out_type", 16'(want.out_type), 16'(got.out_type));
    if (got.out_category !== want.out_category)
      report_field("out_category", 16'(want.out_category), 16'(got.out_category));
    if (got.out_scope !== want.out_scope)
      report_field("out_scope", 16'(want.out_scope), 16'(got.out_scope));
    if (got.out_label !== want.out_label)
      report_field("out_label", want.out_label, got.out_label);
    if (got.out_param_count !== want.out_param_count)
      report_field("out_param_count", 16'(want.out_param_count),
                   16'(got.out_param_count));
  endtask

  // Called at a falling edge; returns at the falling edge after the item is accepted.
  task automatic send_item(input cmd_item_t item, input logic typed, input rsp_item_t want);
    rsp_item_t predicted;
    int        gap;
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      gap = int'($urandom_range(1, 12));
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_item  <= item;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    predicted = predict_response(item);
    expected_rsp.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rsp_hold > 0) begin
      rsp_hold  <= rsp_hold - 1;
      rsp_ready <= 1'b0;
    end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      rsp_hold  <= $urandom_range(0, 11);
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsp.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual %h", $time, rsp_item);
        error_count++;
      end else begin
        compare_response(expected_rsp.pop_front(), rsp_item);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};

    // Empty table, extreme keys, duplicates of both extremes.
    add_row(cmd_item_t'{CMD_LOOKUP, KEY_ZERO, 16'hffff, 1'b1, 2'd3, 1'b1, 16'hffff, 5'd31},
            WANT_GIVEN, rsp_item_t'{ST_NOT_FOUND, 7'd0, 16'h0, 1'b0, 2'd0, 1'b0, 16'h0, 5'd0});
    add_row(cmd_item_t'{CMD_LOOKUP, KEY_ALL_ONES, 16'h0, 1'b0, 2'd0, 1'b0, 16'h0, 5'd0},
            WANT_GIVEN, rsp_item_t'{ST_NOT_FOUND, 7'd0, 16'h0, 1'b0, 2'd0, 1'b0, 16'h0, 5'd0});
    add_row(cmd_item_t'{CMD_INSERT, KEY_ZERO, 16'h0, 1'b0, 2'd0, 1'b0, 16'h0, 5'd0},
            WANT_GIVEN, rsp_item_t'{ST_OK, 7'd0, 16'h0, 1'b0, 2'd0, 1'b0, 16'h0, 5'd0});
    add_row(cmd_item_t'{CMD_INSERT, KEY_ALL_ONES, 16'hffff, 1'b1, 2'd3, 1'b1, 16'hffff, 5'd31},
            WANT_GIVEN, rsp_item_t'{ST_OK, 7'd1, 16'hffff, 1'b1, 2'd3, 1'b1, 16'hffff, 5'd31});
    add_row(cmd_item_t'{CMD_INSERT, KEY_ZERO, 16'h1234, 1'b1, 2'd2, 1'b1, 16'h5678, 5'd7},
            WANT_GIVEN, rsp_item_t'{ST_DUPLICATE, 7'd0, 16'h0, 1'b0, 2'd0, 1'b0, 16'h0, 5'd0});
    add_row(cmd_item_t'{CMD_INSERT, KEY_ALL_ONES, 16'h0, 1'b0, 2'd0, 1'b0, 16'h0, 5'd0},
            WANT_GIVEN,
            rsp_item_t'{ST_DUPLICATE, 7'd1, 16'hffff, 1'b1, 2'd3, 1'b1, 16'hffff, 5'd31});
    add_row(cmd_item_t'{CMD_LOOKUP, KEY_ALL_ONES, 16'h0, 1'b0, 2'd0, 1'b0, 16'h0, 5'd0},
            WANT_GIVEN, rsp_item_t'{ST_OK, 7'd1, 16'hffff, 1'b1, 2'd3, 1'b1, 16'hffff, 5'd31});
    add_row(cmd_item_t'{CMD_LOOKUP, KEY_ZERO, 16'hffff, 1'b1, 2'd3, 1'b1, 16'hffff, 5'd31},
            WANT_GIVEN, rsp_item_t'{ST_OK, 7'd0, 16'h0, 1'b0, 2'd0, 1'b0, 16'h0, 5'd0});
    add_row(cmd_item_t'{CMD_LOOKUP, KEY_TOP, 16'h0, 1'b0, 2'd0, 1'b0, 16'h0, 5'd0},
            WANT_GIVEN, rsp_item_t'{ST_NOT_FOUND, 7'd0, 16'h0, 1'b0, 2'd0, 1'b0, 16'h0, 5'd0});
    add_row(cmd_item_t'{CMD_LOOKUP, 64'h1, 16'h0, 1'b0, 2'd0, 1'b0, 16'h0, 5'd0},
            WANT_GIVEN, rsp_item_t'{ST_NOT_FOUND, 7'd0, 16'h0, 1'b0, 2'd0, 1'b0, 16'h0, 5'd0});

    // Ordinary compiler entries, then an out-of-range category and parameter count.
    add_row(cmd_item_t'{CMD_INSERT, KEY_MAIN, 16'h0000, TYPE_INTEGER, CAT_FUNCTION,
                        SCOPE_GLOBAL, 16'h0010, 5'd0}, WANT_PREDICTED, NO_RSP);
    add_row(cmd_item_t'{CMD_INSERT, KEY_COUNTER, 16'h0004, TYPE_INTEGER, CAT_VARIABLE,
                        SCOPE_LOCAL, 16'h0000, 5'd0}, WANT_PREDICTED, NO_RSP);
    add_row(cmd_item_t'{CMD_INSERT, KEY_N, 16'h0002, TYPE_INTEGER, CAT_PARAMETER,
                        SCOPE_LOCAL, 16'h0011, 5'd20}, WANT_PREDICTED, NO_RSP);
    add_row(cmd_item_t'{CMD_INSERT, KEY_FLAG, 16'h0100, TYPE_LOGICAL, CAT_VARIABLE,
                        SCOPE_GLOBAL, 16'h0000, 5'd0}, WANT_PREDICTED, NO_RSP);
    add_row(cmd_item_t'{CMD_INSERT, KEY_TOP, 16'h8001, TYPE_LOGICAL, CAT_INVALID,
                        SCOPE_LOCAL, 16'hbeef, 5'd21}, WANT_PREDICTED, NO_RSP);
    add_row(cmd_item_t'{CMD_LOOKUP, KEY_MAIN, 16'h0, 1'b0, 2'd0, 1'b0, 16'h0, 5'd0},
            WANT_PREDICTED, NO_RSP);
    add_row(cmd_item_t'{CMD_LOOKUP, KEY_N, 16'h0, 1'b0, 2'd0, 1'b0, 16'h0, 5'd0},
            WANT_PREDICTED, NO_RSP);
    add_row(cmd_item_t'{CMD_LOOKUP, KEY_TOP, 16'h0, 1'b0, 2'd0, 1'b0, 16'h0, 5'd0},
            WANT_PREDICTED, NO_RSP);
    add_row(cmd_item_t'{CMD_LOOKUP, KEY_COUNTER, 16'h0, 1'b0, 2'd0, 1'b0, 16'h0, 5'd0},
            WANT_PREDICTED, NO_RSP);
    add_row(cmd_item_t'{CMD_INSERT, KEY_MAIN, 16'h0040, TYPE_LOGICAL, CAT_VARIABLE,
                        SCOPE_LOCAL, 16'h0001, 5'd3}, WANT_PREDICTED, NO_RSP);
    add_row(cmd_item_t'{CMD_LOOKUP, KEY_MAIO, 16'h0, 1'b0, 2'd0, 1'b0, 16'h0, 5'd0},
            WANT_GIVEN, rsp_item_t'{ST_NOT_FOUND, 7'd0, 16'h0, 1'b0, 2'd0, 1'b0, 16'h0, 5'd0});
    add_row(cmd_item_t'{CMD_LOOKUP, KEY_ALL_ONES ^ 64'h1, 16'h0, 1'b0, 2'd0, 1'b0, 16'h0, 5'd0},
            WANT_GIVEN, rsp_item_t'{ST_NOT_FOUND, 7'd0, 16'h0, 1'b0, 2'd0, 1'b0, 16'h0, 5'd0});

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

    // Random items draw mostly on a fixed pool of keys, so that hits and duplicates are
    // common and the table fills part of the way through.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet_phase = 1'b1;
      if (n == PAUSE_AT) begin
        cmd_valid <= 1'b0;
        while (expected_rsp.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      send_item(random_command(), WANT_PREDICTED, NO_RSP);
    end

    cmd_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
